### rtl/gbsv_pkg.sv
// Package for gene_bits_to_scaled_value: status codes, widths and the divider
// stage record. No dependencies.
package gbsv_pkg;

  localparam int MAX_GENE_BITS = 32;
  localparam int DIV_STAGES    = 32;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_RANGE = 2'd1;
  localparam logic [1:0] ST_BAD_COUNT = 2'd2;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] lo;
    logic [31:0] m;
    logic [31:0] rem;
    logic [31:0] dvd;
    logic [31:0] q;
  } div_t;

  function automatic logic [31:0] gray_dec(input logic [31:0] g);
    logic [31:0] b;
    b = g;
    for (int k = 0; k < 5; k++) begin
      b = b ^ (b >> (1 << k));
    end
    return b;
  endfunction

endpackage

### rtl/gbsv_if.sv
// Channel interfaces for gene_bits_to_scaled_value.
// Depends on nothing but the field widths of the block.
interface gbsv_in_if;
  logic               valid;
  logic               ready;
  logic        [31:0] gene_bits;
  logic        [5:0]  bit_count;
  logic               gray_coded;
  logic signed [31:0] lower_bound;
  logic signed [31:0] upper_bound;
  modport source (output valid, gene_bits, bit_count, gray_coded, lower_bound, upper_bound,
                  input ready);
  modport sink (input valid, gene_bits, bit_count, gray_coded, lower_bound, upper_bound,
                output ready);
endinterface

interface gbsv_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] scaled_value;
  logic        [1:0]  status;
  modport source (output valid, scaled_value, status, input ready);
  modport sink (input valid, scaled_value, status, output ready);
endinterface

### rtl/gene_bits_to_scaled_value.sv
// Top level of gene_bits_to_scaled_value: front stages, divider chain, output.
// Depends on gbsv_pkg, gbsv_if, gbsv_front, gbsv_div_stage.
//
//   channel   direction  contents
//   in_ch     sink       gene_bits, bit_count, gray_coded, lower_bound, upper_bound
//   out_ch    source     scaled_value, status
//
// One transaction per cycle while out_ch is not stalled; 2 front stages, 32 divider
// stages at one quotient bit each, 1 output register.
// Reset clears only the valid bits.
// A stall on out_ch freezes the whole pipeline; nothing is lost or repeated.
module gene_bits_to_scaled_value (
  input  logic        clk,
  input  logic        rst_n,
  gbsv_in_if.sink     in_ch,
  gbsv_out_if.source  out_ch
);

  logic           en;
  logic           out_valid_r;
  logic [31:0]    out_value_r;
  logic [1:0]     out_status_r;
  logic           v [0:gbsv_pkg::DIV_STAGES];
  gbsv_pkg::div_t d [0:gbsv_pkg::DIV_STAGES];
  logic [31:0]    sum;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  gbsv_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .in_valid       (in_ch.valid),
    .in_gene_bits   (in_ch.gene_bits),
    .in_bit_count   (in_ch.bit_count),
    .in_gray_coded  (in_ch.gray_coded),
    .in_lower_bound (in_ch.lower_bound),
    .in_upper_bound (in_ch.upper_bound),
    .out_valid      (v[0]),
    .out_d          (d[0])
  );

  for (genvar i = 0; i < gbsv_pkg::DIV_STAGES; i++) begin : g_div
    gbsv_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (v[i]),
      .in_d      (d[i]),
      .out_valid (v[i+1]),
      .out_d     (d[i+1])
    );
  end

  assign sum = d[gbsv_pkg::DIV_STAGES].lo + d[gbsv_pkg::DIV_STAGES].q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v[gbsv_pkg::DIV_STAGES];
    end
    if (en) begin
      out_status_r <= d[gbsv_pkg::DIV_STAGES].status;
      out_value_r  <= (d[gbsv_pkg::DIV_STAGES].status == gbsv_pkg::ST_OK) ? sum : 32'd0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.scaled_value = out_value_r;
  assign out_ch.status       = out_status_r;

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r == gbsv_pkg::ST_OK || out_status_r == gbsv_pkg::ST_BAD_RANGE
                     || out_status_r == gbsv_pkg::ST_BAD_COUNT))
    else $error("illegal status code");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != gbsv_pkg::ST_OK) |-> (out_value_r == 32'd0))
    else $error("nonzero value on error status");

  a_rem_below_m: assert property (@(posedge clk) disable iff (!rst_n)
    v[gbsv_pkg::DIV_STAGES] |-> (d[gbsv_pkg::DIV_STAGES].rem < d[gbsv_pkg::DIV_STAGES].m))
    else $error("divider remainder not below divisor");

endmodule

### rtl/gbsv_front.sv
// Front stages: decode, status check, span, then the 32x32 product.
// Depends on gbsv_pkg.
module gbsv_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic        [31:0] in_gene_bits,
  input  logic        [5:0]  in_bit_count,
  input  logic               in_gray_coded,
  input  logic signed [31:0] in_lower_bound,
  input  logic signed [31:0] in_upper_bound,
  output logic               out_valid,
  output gbsv_pkg::div_t     out_d
);

  logic        a_valid_r;
  logic [1:0]  a_status_r;
  logic [31:0] a_g_r, a_span_r, a_m_r, a_lo_r;
  logic        b_valid_r;
  gbsv_pkg::div_t b_d_r;

  logic [1:0]  status_nxt;
  logic [32:0] mask_w;
  logic [31:0] mask, g_raw, g_nxt;
  logic [32:0] diff;
  logic [63:0] prod;

  always_comb begin
    if (in_lower_bound >= in_upper_bound) begin
      status_nxt = gbsv_pkg::ST_BAD_RANGE;
    end else if (in_bit_count == 6'd0 || in_bit_count > 6'(gbsv_pkg::MAX_GENE_BITS)) begin
      status_nxt = gbsv_pkg::ST_BAD_COUNT;
    end else begin
      status_nxt = gbsv_pkg::ST_OK;
    end
    mask_w = (33'd1 << in_bit_count) - 33'd1;
    mask   = (status_nxt == gbsv_pkg::ST_OK) ? mask_w[31:0] : 32'd1;
    g_raw  = in_gene_bits & mask;
    g_nxt  = in_gray_coded ? (gbsv_pkg::gray_dec(g_raw) & mask) : g_raw;
    diff   = {in_upper_bound[31], in_upper_bound} - {in_lower_bound[31], in_lower_bound};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
    end
    if (en) begin
      a_status_r <= status_nxt;
      a_g_r      <= (status_nxt == gbsv_pkg::ST_OK) ? g_nxt : 32'd0;
      a_span_r   <= diff[31:0];
      a_m_r      <= mask;
      a_lo_r     <= in_lower_bound;
    end
  end

  assign prod = {32'd0, a_g_r} * {32'd0, a_span_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= a_valid_r;
    end
    if (en) begin
      b_d_r.status <= a_status_r;
      b_d_r.lo     <= a_lo_r;
      b_d_r.m      <= a_m_r;
      b_d_r.rem    <= prod[63:32];
      b_d_r.dvd    <= prod[31:0];
      b_d_r.q      <= 32'd0;
    end
  end

  assign out_valid = b_valid_r;
  assign out_d     = b_d_r;

endmodule

### rtl/gbsv_div_stage.sv
// One restoring-division stage: one quotient bit per stage.
// Depends on gbsv_pkg.
module gbsv_div_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  gbsv_pkg::div_t in_d,
  output logic           out_valid,
  output gbsv_pkg::div_t out_d
);

  logic           valid_r;
  gbsv_pkg::div_t d_r;
  logic [32:0]    t, sub;
  logic           qbit;

  always_comb begin
    t    = {in_d.rem, in_d.dvd[31]};
    sub  = t - {1'b0, in_d.m};
    qbit = (t >= {1'b0, in_d.m});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
    if (en) begin
      d_r.status <= in_d.status;
      d_r.lo     <= in_d.lo;
      d_r.m      <= in_d.m;
      d_r.rem    <= qbit ? sub[31:0] : t[31:0];
      d_r.dvd    <= {in_d.dvd[30:0], 1'b0};
      d_r.q      <= {in_d.q[30:0], qbit};
    end
  end

  assign out_valid = valid_r;
  assign out_d     = d_r;

endmodule

### dv/gene_bits_to_scaled_value_chk.sv
`timescale 1ns / 1ps
// Checker for gene_bits_to_scaled_value: watches both channels, predicts each
// scaled value and status, and compares them in order. Depends on gbsv_pkg, gbsv_if.
module gene_bits_to_scaled_value_chk (
  input  logic       clk,
  input  logic       rst_n,
  gbsv_in_if.sink    in_mon,
  gbsv_out_if.sink   out_mon,
  output int         fail_count,
  output int         pending_count,
  output int         accept_count
);

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } scaled_t;

  scaled_t expected_q[$];
  int      mismatch_count;

  function automatic scaled_t scale_gene(logic [31:0] bits, logic [5:0] n, logic gray,
                                         logic signed [31:0] lo, logic signed [31:0] hi);
    scaled_t     r;
    logic [63:0] mask;
    logic [63:0] g;
    logic [63:0] span;
    logic [63:0] q;
    r.value = '0;
    r.status = gbsv_pkg::ST_OK;
    if (lo >= hi) begin
      r.status = gbsv_pkg::ST_BAD_RANGE;
    end else if (n == 0 || n > gbsv_pkg::MAX_GENE_BITS) begin
      r.status = gbsv_pkg::ST_BAD_COUNT;
    end else begin
      mask = (64'd1 << n) - 64'd1;
      g = {32'd0, bits} & mask;
      if (gray) begin
        for (int k = 30; k >= 0; k--) g[k] = g[k] ^ g[k+1];
        g = g & mask;
      end
      span = 64'($signed(hi)) - 64'($signed(lo));
      span = span & 64'hFFFF_FFFF;
      q = (g * span) / mask;
      r.value = lo + q[31:0];
    end
    return r;
  endfunction

  assign fail_count = mismatch_count;

  always @(posedge clk) begin
    scaled_t e;
    if (!rst_n) begin
      mismatch_count <= 0;
      accept_count <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        expected_q.insert(expected_q.size(),
                          scale_gene(in_mon.gene_bits, in_mon.bit_count,
                                     in_mon.gray_coded, in_mon.lower_bound,
                                     in_mon.upper_bound));
        accept_count <= accept_count + 1;
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          if (mismatch_count < 10) $display("unexpected transaction: value %0d status %0d",
                                            out_mon.scaled_value, out_mon.status);
          mismatch_count <= mismatch_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.value !== out_mon.scaled_value || e.status !== out_mon.status) begin
            if (mismatch_count < 10)
              $display("bad transaction: expected value %0d status %0d, got value %0d status %0d",
                       e.value, e.status, out_mon.scaled_value, out_mon.status);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
    end
    pending_count <= expected_q.size();
  end
endmodule

### dv/gene_bits_to_scaled_value_tb.sv
`timescale 1ns / 1ps
// Testbench top for gene_bits_to_scaled_value: drives genes with random gaps and
// back pressure, then reports the checker's verdict. Depends on gbsv_pkg, gbsv_if, top, checker.
module gene_bits_to_scaled_value_tb;
  localparam int LATENCY = 35;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending_count, accept_count;
  int   idle_cycles;
  int   gap_pct;
  int   stall_pct;
  int   n_ok, n_range, n_count;

  gbsv_in_if  in_ch();
  gbsv_out_if out_ch();

  gene_bits_to_scaled_value u_top (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  gene_bits_to_scaled_value_chk u_chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .fail_count(fail_count), .pending_count(pending_count), .accept_count(accept_count)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.gene_bits = '0;
    in_ch.bit_count = '0;
    in_ch.gray_coded = 1'b0;
    in_ch.lower_bound = '0;
    in_ch.upper_bound = '0;
    out_ch.ready = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("gene_bits_to_scaled_value: mismatch");
      $finish;
    end
  end

  task automatic send_gene(logic [31:0] bits, logic [5:0] n, logic gray,
                           logic signed [31:0] lo, logic signed [31:0] hi);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.gene_bits <= bits;
    in_ch.bit_count <= n;
    in_ch.gray_coded <= gray;
    in_ch.lower_bound <= lo;
    in_ch.upper_bound <= hi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    if (lo >= hi) n_range++;
    else if (n == 0 || n > gbsv_pkg::MAX_GENE_BITS) n_count++;
    else n_ok++;
  endtask

  task automatic send_random_gene();
    logic [31:0] bits, a, b;
    logic [5:0]  n;
    int          sel;
    bits = $urandom();
    sel = $urandom_range(99);
    if (sel < 6) n = 6'($urandom_range(63, 33));
    else if (sel < 8) n = 6'd0;
    else if (sel < 30) n = 6'($urandom_range(8, 1));
    else n = 6'($urandom_range(32, 1));
    a = $urandom();
    b = $urandom();
    sel = $urandom_range(99);
    if (sel < 30) b = a + $urandom_range(65536 * 4, 1);
    if (sel >= 92) b = a;
    if (sel < 88 && $signed(a) > $signed(b)) {a, b} = {b, a};
    if ($signed(a) == $signed(b) && sel < 88) b = a + 1;
    send_gene(bits, n, 1'($urandom_range(1)), a, b);
  endtask

  initial begin
    gap_pct = 0;
    stall_pct = 0;
    n_ok = 0;
    n_range = 0;
    n_count = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_gene(32'hFFFF_FFFF, 6'd32, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_gene(32'h0000_0000, 6'd32, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_gene(32'h8000_0000, 6'd32, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
    send_gene(32'hFFFF_FFFF, 6'd32, 1'b1, 32'hFFFF_0000, 32'h0001_0000);
    send_gene(32'h0000_0001, 6'd1, 1'b0, 32'd0, 32'd1);
    send_gene(32'hFFFF_FFFE, 6'd1, 1'b1, 32'd0, 32'd1);
    send_gene(32'hFFFF_FF05, 6'd4, 1'b1, 32'h0000_0000, 32'h000A_0000);
    send_gene(32'h1234_5678, 6'd16, 1'b0, 32'h0001_0000, 32'h0001_0000);
    send_gene(32'h1234_5678, 6'd16, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_gene(32'h1234_5678, 6'd0, 1'b0, 32'd0, 32'd100);
    send_gene(32'h1234_5678, 6'd33, 1'b1, 32'd0, 32'd100);
    send_gene(32'h1234_5678, 6'd63, 1'b0, 32'd0, 32'd100);
    send_gene(32'h1234_5678, 6'd0, 1'b0, 32'd5, 32'd5);
    send_gene(32'hAAAA_AAAA, 6'd31, 1'b1, 32'h8000_0000, 32'h8000_0001);
    send_gene(32'h5555_5555, 6'd17, 1'b0, 32'h7FFF_FFFE, 32'h7FFF_FFFF);
    for (int i = 0; i < 1800; i++) begin
      if (i == 0) begin
        gap_pct = 0;
        stall_pct = 0;
      end else if (i == 300) begin
        gap_pct = 24;
        stall_pct = 24;
      end else if (i == 1300) begin
        gap_pct = 10;
        stall_pct = 50;
      end else if (i == 1500) begin
        gap_pct = 50;
        stall_pct = 10;
      end
      send_random_gene();
    end
    in_ch.valid <= 1'b0;
    stall_pct = 24;
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    $display("run covered %0d genes: %0d in range, %0d bad range, %0d bad bit count",
             accept_count, n_ok, n_range, n_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("gene_bits_to_scaled_value: match");
    end else begin
      $display("failures: %0d, outstanding: %0d", fail_count, pending_count);
      $display("gene_bits_to_scaled_value: mismatch");
    end
    $finish;
  end
endmodule

### files.f
rtl/gbsv_pkg.sv
rtl/gbsv_if.sv
rtl/gbsv_front.sv
rtl/gbsv_div_stage.sv
rtl/gene_bits_to_scaled_value.sv
dv/gene_bits_to_scaled_value_chk.sv
dv/gene_bits_to_scaled_value_tb.sv
